/* design/bcu_pkg.sv */
// Shared types and constants for the binomial coefficient unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcu_pkg;

    // Field widths
    localparam int IN_W    = 10;              // set_size, subset_size
    localparam int COUNT_W = 30;              // count_value
    localparam int PROD_W  = COUNT_W + IN_W;  // partial product r * (n - i + 1)

    // Stream bus widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Saturation bound for the result
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 30'd1000000000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DIV_WAIT,
        ST_DONE
    } bcu_state_t;

endpackage : bcu_pkg

`default_nettype wire

/* design/bcu_mul.sv */
// Bit-serial shift-add multiplier: COUNT_W x IN_W -> PROD_W, one multiplier bit per cycle.
// Depends on bcu_pkg.
`default_nettype none

module bcu_mul
    import bcu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [COUNT_W-1:0] mcand,
    input  wire logic [IN_W-1:0]    mplier,
    output logic                    done,
    output logic [PROD_W-1:0]       product
);

    localparam int CNT_W = $clog2(IN_W + 1);

    logic [PROD_W-1:0] acc_reg,    acc_next;
    logic [PROD_W-1:0] mcand_reg,  mcand_next;
    logic [IN_W-1:0]   mplier_reg, mplier_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              busy_reg,   busy_next;
    logic              done_reg,   done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = {{IN_W{1'b0}}, mcand};
            mplier_next = mplier;
            cnt_next    = CNT_W'(IN_W);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // add the shifted multiplicand when the low multiplier bit is set
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[IN_W-1:1]};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule : bcu_mul

`default_nettype wire

/* design/bcu_div.sv */
// Bit-serial restoring divider: PROD_W / IN_W, one quotient bit per cycle.
// Depends on bcu_pkg. Divisor must be nonzero.
`default_nettype none

module bcu_div
    import bcu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [IN_W-1:0]   divisor,
    output logic                   done,
    output logic [PROD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg,  quo_next;
    logic [IN_W-1:0]   rem_reg,  rem_next;
    logic [IN_W-1:0]   dvs_reg,  dvs_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [IN_W:0]     trial;
    logic [IN_W:0]     diff;
    logic              fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // a failed trial is below the divisor, so it fits in IN_W bits
            rem_next = fits ? diff[IN_W-1:0] : trial[IN_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : bcu_div

`default_nettype wire

/* design/binomial_coefficient_unit.sv */
// Binomial coefficient unit, top level: stream ports, sequencer, serial datapath.
// Depends on bcu_pkg, bcu_mul and bcu_div.
//
// Takes a pair (n, k) and returns C(n,k), saturated at one billion with an
// overflow flag; k > n returns 0. The block walks the multiplicative rule
// r = r * (n - i + 1) / i for i = 1 .. m, m = min(k, n - k), and every
// step runs through a bit-serial multiplier (one multiplier bit per cycle)
// and then a bit-serial restoring divider (one quotient bit per cycle).
// Each step worked passes through ST_MUL (launch the multiply), then
// ST_MUL_WAIT (multiply and hand on), then ST_DIV_WAIT (divide); k > n,
// k = 0 and k = n work no steps and go straight to ST_DONE. A step whose
// quotient passes one billion ends the item early, which caps the number
// of steps at 16 (C(32,16) is the longest run that stays under the bound).
// One item is worked at a time; the result sits in an output register, so
// the next pair is taken while a finished result still waits on m_tready.
`default_nettype none

module binomial_coefficient_unit
    import bcu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [9:0] set_size, [19:10] subset_size
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [29:0] count_value, [30] overflow_flag
);

    bcu_state_t         state_reg, state_next;
    logic [IN_W-1:0]    n_reg,     n_next;
    logic [IN_W-1:0]    m_reg,     m_next;     // number of steps, min(k, n-k)
    logic [IN_W-1:0]    i_reg,     i_next;     // current step, from 1
    logic [COUNT_W-1:0] r_reg,     r_next;     // running value, C(n, i-1)
    logic               ovf_reg,   ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_ovf_reg,   out_ovf_next;

    logic               mul_start, mul_done;
    logic               div_start, div_done;
    logic [PROD_W-1:0]  product, quotient;
    logic [IN_W-1:0]    factor;

    logic [IN_W-1:0]    in_n, in_k, in_rest;

    assign in_n    = s_tdata[IN_W-1:0];
    assign in_k    = s_tdata[2*IN_W-1:IN_W];
    assign in_rest = in_n - in_k;
    assign factor  = n_reg - i_reg + IN_W'(1);

    bcu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (r_reg),
        .mplier  (factor),
        .done    (mul_done),
        .product (product)
    );

    bcu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (i_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg         <= n_next;
        m_reg         <= m_next;
        i_reg         <= i_next;
        r_reg         <= r_next;
        ovf_reg       <= ovf_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        ovf_next       = ovf_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        // drop the held result once the downstream side takes it
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_next   = in_n;
                    i_next   = IN_W'(1);
                    r_next   = COUNT_W'(1);
                    ovf_next = 1'b0;
                    m_next   = (in_rest < in_k) ? in_rest : in_k;
                    if (in_k > in_n) begin
                        // subset larger than set: no subsets at all
                        r_next     = '0;
                        state_next = ST_DONE;
                    end else if (in_k == '0 || in_k == in_n) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                // product holds once the multiplier is done; hand it on
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (quotient > {{IN_W{1'b0}}, COUNT_LIMIT}) begin
                        // values only rise from here: saturate and stop
                        r_next     = COUNT_LIMIT;
                        ovf_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        r_next = quotient[COUNT_W-1:0];
                        if (i_reg == m_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            i_next     = i_reg + IN_W'(1);
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_DONE: begin
                // load the output register when it is free or being emptied
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_count_next = r_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W-1){1'b0}}, out_ovf_reg, out_count_reg};

endmodule : binomial_coefficient_unit

`default_nettype wire

/* design/bcu_checker.sv */
// Port-level checks for the binomial coefficient unit, bound to its top level.
// Depends on bcu_pkg and binomial_coefficient_unit.
`default_nettype none

module bcu_checker
    import bcu_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // one pair in flight: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a pair is in work");

    // never exceed the saturation bound
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[COUNT_W-1:0] <= COUNT_LIMIT))
        else $error("count above the saturation bound");

    // overflow comes with the saturated value
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[COUNT_W]) |-> (m_tdata[COUNT_W-1:0] == COUNT_LIMIT))
        else $error("overflow without saturated count");

    // padding bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:COUNT_W+1] == '0))
        else $error("padding bits set in result");

endmodule : bcu_checker

bind binomial_coefficient_unit bcu_checker u_bcu_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for binomial_coefficient_unit: stream stimulus, C(n,k) prediction.
// Depends on bcu_pkg and the binomial_coefficient_unit RTL; reads no files.
`timescale 1ns / 100ps

module tb;
    import bcu_pkg::*;

    // Expected result for one accepted (n, k) transaction
    typedef struct packed {
        logic [IN_W-1:0]    set_size;
        logic [IN_W-1:0]    subset_size;
        logic [COUNT_W-1:0] count_value;
        logic               overflow_flag;
    } subset_count_t;

    // Scoreboard: predicts C(n,k) per accepted pair and checks results in order
    class count_tracker;
        subset_count_t pending_counts[$];
        int errors;
        int checked;
        int saturated;
        int oversized_subsets;

        function new();
            errors            = 0;
            checked           = 0;
            saturated         = 0;
            oversized_subsets = 0;
        endfunction

        // Multiplicative rule on the smaller side, saturating at the count limit
        function subset_count_t count_subsets(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
            subset_count_t     res;
            longint unsigned   acc;
            longint unsigned   steps;
            longint unsigned   i;
            res.set_size      = n;
            res.subset_size   = k;
            res.count_value   = '0;
            res.overflow_flag = 1'b0;
            if (k > n) begin
                return res;
            end
            steps = ((n - k) < k) ? longint'(n - k) : longint'(k);
            acc   = 1;
            for (i = 1; i <= steps; i++) begin
                acc = (acc * (longint'(n) - i + 1)) / i;
                if (acc > COUNT_LIMIT) begin
                    acc               = COUNT_LIMIT;
                    res.overflow_flag = 1'b1;
                    break;
                end
            end
            res.count_value = acc[COUNT_W-1:0];
            return res;
        endfunction

        function void note_pair(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
            pending_counts.push_back(count_subsets(n, k));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            subset_count_t exp_res;
            logic [COUNT_W-1:0] got_count;
            logic               got_ovf;
            got_count = word[COUNT_W-1:0];
            got_ovf   = word[COUNT_W];
            if (pending_counts.size() == 0) begin
                $error("result transaction with no pair pending: count_value %0d", got_count);
                errors++;
                return;
            end
            exp_res = pending_counts.pop_front();
            checked++;
            if (exp_res.overflow_flag) saturated++;
            if (exp_res.subset_size > exp_res.set_size) oversized_subsets++;
            if (got_count !== exp_res.count_value) begin
                $error("count_value for C(%0d,%0d): expected %0d, got %0d",
                       exp_res.set_size, exp_res.subset_size, exp_res.count_value, got_count);
                errors++;
            end
            if (got_ovf !== exp_res.overflow_flag) begin
                $error("overflow_flag for C(%0d,%0d): expected %0d, got %0d",
                       exp_res.set_size, exp_res.subset_size, exp_res.overflow_flag, got_ovf);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_counts.size();
        endfunction
    endclass

    localparam int CLK_HALF     = 4;
    localparam int DIR_COUNT    = 24;
    localparam int RANDOM_ITEMS = 70;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 200;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [9:0] set_size, [19:10] subset_size
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [29:0] count_value, [30] overflow_flag

    count_tracker tracker = new();

    // Shared knobs between the sender and the receiver
    bit quiet;               // suppress random idling on both sides
    int hold_request;        // receiver stall length, picked up by the receiver loop

    // Directed pairs: field extremes, k > n, k = 0 and k = n, saturation edges
    logic [IN_W-1:0] dir_set [DIR_COUNT] = '{
        10'd0,    10'd0,    10'd1,    10'd1,    10'd5,    10'd0,
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd1000, 10'd1000, 10'd1000, 10'd32,   10'd33,   10'd34,
        10'd30,   10'd512,  10'd682,  10'd20,   10'd1022, 10'd2
    };
    logic [IN_W-1:0] dir_sub [DIR_COUNT] = '{
        10'd0,    10'd1,    10'd0,    10'd1,    10'd7,    10'd1023,
        10'd0,    10'd1023, 10'd1,    10'd1022, 10'd511,  10'd512,
        10'd3,    10'd4,    10'd500,  10'd16,   10'd16,   10'd17,
        10'd15,   10'd511,  10'd341,  10'd10,   10'd2,    10'd2
    };

    binomial_coefficient_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Offer one pair; hold it until the input handshake completes
    task automatic offer_pair(input logic [IN_W-1:0] n, input logic [IN_W-1:0] k);
        int gap;
        gap = (!quiet && $urandom_range(99) < 13) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 2*IN_W){1'b0}}, k, n};
        do @(posedge aclk); while (!s_tready);
        tracker.note_pair(n, k);
    endtask

    // Pick a pair from one of several regions of interest
    task automatic pick_pair(output logic [IN_W-1:0] n, output logic [IN_W-1:0] k);
        int unsigned dist_n;
        case ($urandom_range(3))
            0: begin
                // anything the fields allow, k > n about half the time
                n = IN_W'($urandom_range(1023));
                k = IN_W'($urandom_range(1023));
            end
            1: begin
                // small sets, k up to n + 3: full multiply/divide runs, some saturating
                n = IN_W'($urandom_range(40));
                k = IN_W'($urandom_range(n + 3));
            end
            2: begin
                // k near 0 or near n, across the whole set range
                n = IN_W'($urandom_range(1023));
                dist_n = $urandom_range(5);
                if ($urandom_range(1)) k = IN_W'(dist_n);
                else k = (dist_n > n) ? '0 : IN_W'(n - dist_n);
            end
            default: begin
                // well-formed pairs within the expected set range
                n = IN_W'($urandom_range(1000));
                k = IN_W'($urandom_range(n));
            end
        endcase
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [IN_W-1:0] n;
        logic [IN_W-1:0] k;
        repeat (count) begin
            pick_pair(n, k);
            offer_pair(n, k);
        end
    endtask

    // Result side: check accepted transactions, then pick next-cycle ready
    initial begin
        int hold_left;
        bit ready_next;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = quiet || ($urandom_range(99) >= 13);
            end
            m_tready <= ready_next;
        end
    end

    // Main sequence
    initial begin
        quiet        = 1'b0;
        hold_request = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners
        for (int idx = 0; idx < DIR_COUNT; idx++) begin
            offer_pair(dir_set[idx], dir_sub[idx]);
        end

        // Pause the sender until the block is fully drained
        drain_results();

        // Stall the receiver for a long stretch while pairs keep coming,
        // so the output register and the sequencer both fill up
        hold_request = HOLD_CYCLES;
        send_random(6);

        // Random traffic, with a middle stretch free of idling
        send_random(RANDOM_ITEMS / 3);
        quiet = 1'b1;
        send_random(RANDOM_ITEMS / 3);
        quiet = 1'b0;
        send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        drain_results();
        // Watch a while longer for any stray result transaction
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d results: %0d saturated, %0d with subset larger than set.",
                 tracker.checked, tracker.saturated, tracker.oversized_subsets);
        $display("Included directed corners, a long receiver stall and a no-idle stretch.");
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: covers the slowest legal run several times over
    initial begin
        #(80_000_000);
        $display("Timeout with %0d results outstanding", tracker.outstanding());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
design/bcu_pkg.sv
design/bcu_mul.sv
design/bcu_div.sv
design/binomial_coefficient_unit.sv
design/bcu_checker.sv
tb/tb.sv
